// ----- rtl/hcb_pkg.sv -----
// shared types and codes of the huffman code builder
// used by hcb_heap and huffman_code_builder_top
package hcb_pkg;

  localparam int unsigned SYM_W   = 8;
  localparam int unsigned NODE_W  = 9;
  localparam int unsigned CNT_W   = 9;
  localparam int unsigned LEN_W   = 5;
  localparam int unsigned WORD_W  = 31;
  localparam int unsigned DEPTH_W = 6;
  localparam int unsigned CODE_W  = LEN_W + WORD_W;
  localparam int unsigned LINK_W  = 2 * NODE_W;
  localparam int unsigned INFO_W  = DEPTH_W + WORD_W;
  localparam int unsigned SLOTS   = 256;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_BUILD = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } hcb_heap_req_t;

  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] len;
  } hcb_heap_rsp_t;

endpackage

// ----- rtl/hcb_heap.sv -----
// binary min-heap of weighted nodes with one shared weight comparator
// depends on hcb_pkg
module hcb_heap #(
  parameter int unsigned ENTRY_W = 49
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  hcb_pkg::hcb_heap_req_t req_i,
  input  logic [ENTRY_W-1:0]    entry_i,
  output hcb_pkg::hcb_heap_rsp_t rsp_o,
  output logic [ENTRY_W-1:0]    top_o
);

  localparam logic [2:0] H_IDLE   = 3'd0;
  localparam logic [2:0] H_UP_RD  = 3'd1;
  localparam logic [2:0] H_UP_CMP = 3'd2;
  localparam logic [2:0] H_POP_LD = 3'd3;
  localparam logic [2:0] H_DN_RD  = 3'd4;
  localparam logic [2:0] H_DN_L   = 3'd5;
  localparam logic [2:0] H_DN_R   = 3'd6;

  logic [ENTRY_W-1:0] mem [hcb_pkg::SLOTS];
  logic [ENTRY_W-1:0] rd0_q, rd1_q;

  logic [2:0]         state_q, state_d;
  logic [8:0]         len_q, len_d;
  logic [7:0]         i_q, i_d;
  logic [ENTRY_W-1:0] x_q, x_d, top_q, top_d, m_q, m_d;
  logic               m_is_x_q, m_is_x_d;
  logic [7:0]         m_idx_q, m_idx_d;

  logic               we, re;
  logic [7:0]         waddr, raddr0, raddr1;
  logic [ENTRY_W-1:0] wdata;
  logic [ENTRY_W-1:0] cmp_a, cmp_b;
  logic               gt;
  logic [7:0]         par;
  logic [8:0]         lch;
  logic [9:0]         rch;

  assign par = 8'((i_q - 8'd1) >> 1);
  assign lch = {i_q, 1'b1};
  assign rch = 10'(lch) + 10'd1;
  assign gt  = cmp_a[ENTRY_W-1:hcb_pkg::NODE_W] > cmp_b[ENTRY_W-1:hcb_pkg::NODE_W];

  always_comb begin
    state_d  = state_q;
    len_d    = len_q;
    i_d      = i_q;
    x_d      = x_q;
    top_d    = top_q;
    m_d      = m_q;
    m_is_x_d = m_is_x_q;
    m_idx_d  = m_idx_q;
    we       = 1'b0;
    re       = 1'b0;
    waddr    = i_q;
    wdata    = x_q;
    raddr0   = par;
    raddr1   = 8'd0;
    cmp_a    = x_q;
    cmp_b    = rd0_q;
    unique case (state_q)
      H_IDLE: begin
        if (req_i.clear) begin
          len_d = '0;
        end else if (req_i.push) begin
          x_d     = entry_i;
          i_d     = len_q[7:0];
          len_d   = len_q + 9'd1;
          state_d = H_UP_RD;
        end else if (req_i.pop) begin
          re      = 1'b1;
          raddr0  = 8'd0;
          raddr1  = 8'(len_q - 9'd1);
          len_d   = len_q - 9'd1;
          state_d = H_POP_LD;
        end
      end
      H_UP_RD: begin
        if (i_q == 8'd0) begin
          we      = 1'b1;
          state_d = H_IDLE;
        end else begin
          re      = 1'b1;
          state_d = H_UP_CMP;
        end
      end
      H_UP_CMP: begin
        cmp_a = rd0_q;
        cmp_b = x_q;
        we    = 1'b1;
        if (gt) begin
          wdata   = rd0_q;
          i_d     = par;
          state_d = H_UP_RD;
        end else begin
          state_d = H_IDLE;
        end
      end
      H_POP_LD: begin
        top_d   = rd0_q;
        x_d     = rd1_q;
        i_d     = 8'd0;
        state_d = H_DN_RD;
      end
      H_DN_RD: begin
        if (lch >= len_q) begin
          we      = 1'b1;
          state_d = H_IDLE;
        end else begin
          re      = 1'b1;
          raddr0  = lch[7:0];
          raddr1  = rch[7:0];
          state_d = H_DN_L;
        end
      end
      H_DN_L: begin
        if (gt) begin
          m_d      = rd0_q;
          m_is_x_d = 1'b0;
          m_idx_d  = lch[7:0];
        end else begin
          m_d      = x_q;
          m_is_x_d = 1'b1;
        end
        state_d = H_DN_R;
      end
      H_DN_R: begin
        cmp_a = m_q;
        cmp_b = rd1_q;
        we    = 1'b1;
        if (rch < 10'(len_q) && gt) begin
          wdata   = rd1_q;
          i_d     = rch[7:0];
          state_d = H_DN_RD;
        end else if (m_is_x_q) begin
          state_d = H_IDLE;
        end else begin
          wdata   = m_q;
          i_d     = m_idx_q;
          state_d = H_DN_RD;
        end
      end
      default: state_d = H_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
      len_q   <= '0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q      <= i_d;
    x_q      <= x_d;
    top_q    <= top_d;
    m_q      <= m_d;
    m_is_x_q <= m_is_x_d;
    m_idx_q  <= m_idx_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd0_q <= mem[raddr0];
      rd1_q <= mem[raddr1];
    end
  end

  assign rsp_o.busy = (state_q != H_IDLE);
  assign rsp_o.len  = len_q;
  assign top_o      = top_q;

endmodule

// ----- rtl/huffman_code_builder_top.sv -----
// huffman code builder top: frequency and code stores, tree links and build sequencer
// depends on hcb_pkg and hcb_heap
//
// op 0 stores a symbol's count, op 1 builds the codes, op 2 reads one symbol's code.
// a build scans the whole table, inserts every present symbol into the heap, then
// for each of the n-1 merges does two extractions and one insert, and finally walks
// the tree, reading each node's links and writing depth and code for both children;
// the single heap unit with its one comparator bounds how fast this runs. the block
// takes no new transaction until its result has been taken.
module huffman_code_builder_top #(
  parameter int unsigned SYMBOLS   = 256,
  parameter int unsigned MAX_LEN   = 32,
  parameter int unsigned FREQ_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  symbol_i,
  input  logic [31:0] frequency_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  code_length_o,
  output logic [30:0] code_word_o,
  output logic        has_code_o,
  output logic        too_deep_o,
  output logic [8:0]  symbol_count_o
);

  localparam int unsigned W     = FREQ_BITS + 8;
  localparam int unsigned E     = W + hcb_pkg::NODE_W;
  localparam logic [8:0]  SYM_LIM = 9'(SYMBOLS);
  localparam logic [5:0]  LEN_LIM = 6'(MAX_LEN);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_READ     = 5'd1;
  localparam logic [4:0] S_SCAN_RD  = 5'd2;
  localparam logic [4:0] S_SCAN_CHK = 5'd3;
  localparam logic [4:0] S_SCAN_WT  = 5'd4;
  localparam logic [4:0] S_SCAN_END = 5'd5;
  localparam logic [4:0] S_MERGE    = 5'd6;
  localparam logic [4:0] S_WAIT_A   = 5'd7;
  localparam logic [4:0] S_POP_B    = 5'd8;
  localparam logic [4:0] S_WAIT_B   = 5'd9;
  localparam logic [4:0] S_WAIT_P   = 5'd10;
  localparam logic [4:0] S_T_RD     = 5'd11;
  localparam logic [4:0] S_T_LD     = 5'd12;
  localparam logic [4:0] S_T_C0     = 5'd13;
  localparam logic [4:0] S_T_C1     = 5'd14;
  localparam logic [4:0] S_DONE     = 5'd15;

  logic [FREQ_BITS-1:0]        freq_mem [hcb_pkg::SLOTS];
  logic [hcb_pkg::SLOTS-1:0]   freq_vld_q;
  logic [FREQ_BITS-1:0]        freq_rd_q;
  logic                        freq_rd_vld_q;
  logic [hcb_pkg::CODE_W-1:0]  code_mem [hcb_pkg::SLOTS];
  logic [hcb_pkg::SLOTS-1:0]   code_vld_q;
  logic [hcb_pkg::CODE_W-1:0]  code_rd_q;
  logic                        code_rd_vld_q;
  logic [hcb_pkg::LINK_W-1:0]  link_mem [hcb_pkg::SLOTS-1];
  logic [hcb_pkg::LINK_W-1:0]  link_rd_q;
  logic [hcb_pkg::INFO_W-1:0]  info_mem [hcb_pkg::SLOTS-1];
  logic [hcb_pkg::INFO_W-1:0]  info_rd_q;

  logic [4:0]  state_q, state_d;
  logic [8:0]  scan_q, scan_d, cnt_q, cnt_d;
  logic [7:0]  first_q, first_d, k_q, k_d;
  logic        root_q, root_d;
  logic [E-1:0] a_q, a_d;
  logic [8:0]  ca_q, ca_d, cb_q, cb_d;
  logic [5:0]  d_q, d_d;
  logic [30:0] c_q, c_d;
  logic        out_valid_q, out_valid_d;
  logic [4:0]  len_out_q, len_out_d;
  logic [30:0] word_out_q, word_out_d;
  logic        has_q, has_d, deep_q, deep_d;
  logic [8:0]  count_q, count_d;

  logic        freq_we, freq_re, code_we, code_re, code_clr, link_we, link_re, info_we;
  logic [7:0]  freq_raddr, code_waddr, code_raddr, info_waddr;
  logic [hcb_pkg::CODE_W-1:0] code_wdata;
  logic [hcb_pkg::LINK_W-1:0] link_wdata;
  logic [hcb_pkg::INFO_W-1:0] info_wdata;

  hcb_pkg::hcb_heap_req_t heap_req;
  hcb_pkg::hcb_heap_rsp_t heap_rsp;
  logic [E-1:0] heap_entry, heap_top;

  logic [FREQ_BITS-1:0] f_cur;
  logic [hcb_pkg::CODE_W-1:0] e_cur;
  logic        bit_sel;
  logic [8:0]  child;
  logic [5:0]  dch;
  logic [30:0] cch;

  hcb_heap #(
    .ENTRY_W(E)
  ) u_heap (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (heap_req),
    .entry_i(heap_entry),
    .rsp_o  (heap_rsp),
    .top_o  (heap_top)
  );

  assign f_cur   = freq_rd_vld_q ? freq_rd_q : '0;
  assign e_cur   = code_rd_vld_q ? code_rd_q : '0;
  assign bit_sel = (state_q == S_T_C1);
  assign child   = bit_sel ? cb_q : ca_q;
  assign dch     = (d_q >= LEN_LIM) ? LEN_LIM : d_q + 6'd1;
  assign cch     = {c_q[29:0], bit_sel};

  always_comb begin
    state_d     = state_q;
    scan_d      = scan_q;
    cnt_d       = cnt_q;
    first_d     = first_q;
    k_d         = k_q;
    root_d      = root_q;
    a_d         = a_q;
    ca_d        = ca_q;
    cb_d        = cb_q;
    d_d         = d_q;
    c_d         = c_q;
    out_valid_d = out_valid_q;
    len_out_d   = len_out_q;
    word_out_d  = word_out_q;
    has_d       = has_q;
    deep_d      = deep_q;
    count_d     = count_q;
    freq_we     = 1'b0;
    freq_re     = 1'b0;
    freq_raddr  = scan_q[7:0];
    code_we     = 1'b0;
    code_re     = 1'b0;
    code_clr    = 1'b0;
    code_waddr  = scan_q[7:0];
    code_raddr  = symbol_i;
    code_wdata  = {{hcb_pkg::LEN_W{1'b0}}, 31'd1};
    link_we     = 1'b0;
    link_re     = 1'b0;
    link_wdata  = {heap_top[hcb_pkg::NODE_W-1:0], a_q[hcb_pkg::NODE_W-1:0]};
    info_we     = 1'b0;
    info_waddr  = child[7:0];
    info_wdata  = {dch, cch};
    heap_req    = '0;
    heap_entry  = {{(W-FREQ_BITS){1'b0}}, f_cur, 1'b0, scan_q[7:0]};

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          len_out_d  = '0;
          word_out_d = '0;
          has_d      = 1'b0;
          deep_d     = 1'b0;
          count_d    = '0;
          unique case (op_i)
            hcb_pkg::OP_WRITE: begin
              freq_we     = (9'(symbol_i) < SYM_LIM);
              out_valid_d = 1'b1;
            end
            hcb_pkg::OP_BUILD: begin
              code_clr      = 1'b1;
              heap_req.clear = 1'b1;
              scan_d        = '0;
              cnt_d         = '0;
              state_d       = S_SCAN_RD;
            end
            hcb_pkg::OP_READ: begin
              if (9'(symbol_i) < SYM_LIM) begin
                code_re = 1'b1;
                state_d = S_READ;
              end else begin
                out_valid_d = 1'b1;
              end
            end
            default: out_valid_d = 1'b1;
          endcase
        end
      end
      S_READ: begin
        if (e_cur[35:31] != 5'd0) begin
          len_out_d  = e_cur[35:31];
          word_out_d = e_cur[30:0];
          has_d      = 1'b1;
        end else begin
          deep_d = (e_cur[30:0] == 31'd1);
        end
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      S_SCAN_RD: begin
        if (scan_q == SYM_LIM) begin
          state_d = S_SCAN_END;
        end else begin
          freq_re = 1'b1;
          state_d = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (f_cur != '0) begin
          code_we       = 1'b1;
          heap_req.push = 1'b1;
          if (cnt_q == 9'd0) begin
            first_d = scan_q[7:0];
          end
          cnt_d   = cnt_q + 9'd1;
          state_d = S_SCAN_WT;
        end else begin
          scan_d  = scan_q + 9'd1;
          state_d = S_SCAN_RD;
        end
      end
      S_SCAN_WT: begin
        if (!heap_rsp.busy) begin
          scan_d  = scan_q + 9'd1;
          state_d = S_SCAN_RD;
        end
      end
      S_SCAN_END: begin
        if (cnt_q == 9'd0) begin
          state_d = S_DONE;
        end else if (cnt_q == 9'd1) begin
          code_we    = 1'b1;
          code_waddr = first_q;
          code_wdata = {5'd1, 31'd0};
          state_d    = S_DONE;
        end else begin
          k_d     = '0;
          state_d = S_MERGE;
        end
      end
      S_MERGE: begin
        if (heap_rsp.len > 9'd1) begin
          heap_req.pop = 1'b1;
          state_d      = S_WAIT_A;
        end else begin
          k_d     = k_q - 8'd1;
          root_d  = 1'b1;
          state_d = S_T_RD;
        end
      end
      S_WAIT_A: begin
        if (!heap_rsp.busy) begin
          a_d     = heap_top;
          state_d = S_POP_B;
        end
      end
      S_POP_B: begin
        heap_req.pop = 1'b1;
        state_d      = S_WAIT_B;
      end
      S_WAIT_B: begin
        if (!heap_rsp.busy) begin
          heap_entry    = {a_q[E-1:hcb_pkg::NODE_W] + heap_top[E-1:hcb_pkg::NODE_W],
                           1'b1, k_q};
          heap_req.push = 1'b1;
          link_we       = 1'b1;
          k_d           = k_q + 8'd1;
          state_d       = S_WAIT_P;
        end
      end
      S_WAIT_P: begin
        if (!heap_rsp.busy) begin
          state_d = S_MERGE;
        end
      end
      S_T_RD: begin
        link_re = 1'b1;
        state_d = S_T_LD;
      end
      S_T_LD: begin
        ca_d    = link_rd_q[8:0];
        cb_d    = link_rd_q[17:9];
        d_d     = root_q ? 6'd0 : info_rd_q[36:31];
        c_d     = root_q ? 31'd0 : info_rd_q[30:0];
        root_d  = 1'b0;
        state_d = S_T_C0;
      end
      S_T_C0, S_T_C1: begin
        if (child[8]) begin
          info_we = 1'b1;
        end else if (dch < LEN_LIM) begin
          code_we    = 1'b1;
          code_waddr = child[7:0];
          code_wdata = {dch[4:0], cch};
        end
        if (!bit_sel) begin
          state_d = S_T_C1;
        end else if (k_q == 8'd0) begin
          state_d = S_DONE;
        end else begin
          k_d     = k_q - 8'd1;
          state_d = S_T_RD;
        end
      end
      S_DONE: begin
        count_d     = cnt_q;
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE) && !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      freq_vld_q  <= '0;
      code_vld_q  <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (freq_we) begin
        freq_vld_q[symbol_i] <= 1'b1;
      end
      if (code_clr) begin
        code_vld_q <= '0;
      end else if (code_we) begin
        code_vld_q[code_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q     <= scan_d;
    cnt_q      <= cnt_d;
    first_q    <= first_d;
    k_q        <= k_d;
    root_q     <= root_d;
    a_q        <= a_d;
    ca_q       <= ca_d;
    cb_q       <= cb_d;
    d_q        <= d_d;
    c_q        <= c_d;
    len_out_q  <= len_out_d;
    word_out_q <= word_out_d;
    has_q      <= has_d;
    deep_q     <= deep_d;
    count_q    <= count_d;
  end

  always_ff @(posedge clk_i) begin
    if (freq_we) begin
      freq_mem[symbol_i] <= frequency_i[FREQ_BITS-1:0];
    end
    if (freq_re) begin
      freq_rd_q     <= freq_mem[freq_raddr];
      freq_rd_vld_q <= freq_vld_q[freq_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (code_we) begin
      code_mem[code_waddr] <= code_wdata;
    end
    if (code_re) begin
      code_rd_q     <= code_mem[code_raddr];
      code_rd_vld_q <= code_vld_q[code_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[k_q] <= link_wdata;
    end
    if (link_re) begin
      link_rd_q <= link_mem[k_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (info_we) begin
      info_mem[info_waddr] <= info_wdata;
    end
    if (link_re) begin
      info_rd_q <= info_mem[k_q];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign code_length_o  = len_out_q;
  assign code_word_o    = word_out_q;
  assign has_code_o     = has_q;
  assign too_deep_o     = deep_q;
  assign symbol_count_o = count_q;

`ifndef SYNTHESIS
  a_ready_heap_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !heap_rsp.busy)
    else $error("ready while heap busy");
  a_code_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(has_code_o && too_deep_o))
    else $error("code and too deep together");
  a_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_code_o) |-> (code_word_o == '0))
    else $error("code word without code");
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second transaction taken too early");
`endif

endmodule
